@@ hdl/vfgp_pkg.sv @@
// ----------------------------------------------------------------------------
// vfgp_pkg
// Shared types and constants of the voice fade, gain and pan mixer.
// ----------------------------------------------------------------------------
package vfgp_pkg;

    // fixed field widths
    localparam int OPCODE_BITS    = 3;
    localparam int POS_BITS       = 32;
    localparam int GAIN_BITS      = 16;
    localparam int PAN_BITS       = 16;
    localparam int PF_BITS        = 15;
    localparam int GP_BITS        = GAIN_BITS + PF_BITS;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    // gain Q4.12 times pan Q1.14 gives 26 fraction bits
    localparam int PRODUCT_SHIFT = 26;

    localparam logic [GAIN_BITS-1:0]       GAIN_RESET = 16'd4096;
    localparam logic signed [PAN_BITS-1:0] PAN_MAX    = 16'sd16384;
    localparam logic signed [PAN_BITS-1:0] PAN_MIN    = -16'sd16384;
    localparam logic [PF_BITS-1:0]         PAN_UNITY  = 15'd16384;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_FRAME    = 3'd0,
        OP_FADE_IN  = 3'd1,
        OP_FADE_OUT = 3'd2,
        OP_PLAY     = 3'd3,
        OP_PAUSE    = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        RAMP_NONE = 2'd0,
        RAMP_IN   = 2'd1,
        RAMP_OUT  = 2'd2
    } ramp_mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GAIN = 2'd0,
        CFG_PAN  = 2'd1,
        CFG_MUTE = 2'd2,
        CFG_MONO = 2'd3
    } cfg_index_t;

    // lane handshake toward the merge stage
    typedef struct packed {
        logic busy;
        logic rdy;
    } lane_stat_t;

    // voice status reported with each result word
    typedef struct packed {
        logic                playing;
        ramp_mode_t          ramp_mode;
        logic [POS_BITS-1:0] frame_count;
    } voice_stat_t;

endpackage

@@ hdl/vfgp_if.sv @@
// ----------------------------------------------------------------------------
// vfgp_if
// Valid/ready channel interfaces for input words and result words.
// ----------------------------------------------------------------------------
interface vfgp_in_if #(
    parameter int SAMPLE_BITS   = 16,
    parameter int BUS_BITS      = 24,
    parameter int RAMP_LEN_BITS = 24
);
    logic                              valid;
    logic                              ready;
    logic [vfgp_pkg::OPCODE_BITS-1:0]  opcode;
    logic signed [SAMPLE_BITS-1:0]     sample_left;
    logic signed [SAMPLE_BITS-1:0]     sample_right;
    logic signed [BUS_BITS-1:0]        bus_in_left;
    logic signed [BUS_BITS-1:0]        bus_in_right;
    logic [RAMP_LEN_BITS-1:0]          ramp_length;

    modport source (
        output valid, opcode, sample_left, sample_right, bus_in_left, bus_in_right,
               ramp_length,
        input  ready
    );

    modport sink (
        input  valid, opcode, sample_left, sample_right, bus_in_left, bus_in_right,
               ramp_length,
        output ready
    );
endinterface

interface vfgp_out_if #(
    parameter int BUS_BITS = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [BUS_BITS-1:0]     bus_out_left;
    logic signed [BUS_BITS-1:0]     bus_out_right;
    logic                           is_playing;
    logic [1:0]                     ramp_state;
    logic [vfgp_pkg::POS_BITS-1:0]  position_now;

    modport source (
        output valid, bus_out_left, bus_out_right, is_playing, ramp_state, position_now,
        input  ready
    );

    modport sink (
        input  valid, bus_out_left, bus_out_right, is_playing, ramp_state, position_now,
        output ready
    );
endinterface

@@ hdl/voice_fade_gain_pan_mixer.sv @@
// ----------------------------------------------------------------------------
// voice_fade_gain_pan_mixer
// One voice with linear fade ramp, gain and clipped linear pan, mixed onto
// a stereo bus with saturation. Two channel lanes and a merge stage.
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// item      in   valid/ready    opcode, sample_left/right, bus_in_left/right,
//                               ramp_length
// result    out  valid/ready    bus_out_left/right, is_playing, ramp_state,
//                               position_now
// cfg       in   cfg_write      cfg_index, cfg_data (gain, pan, mute, mono)
//
// any word taken while a fade is running passes through the one-bit-a-cycle
//   ramp divider in each lane before the gain, pan and sum steps; every other
//   word skips the divider; the next word is taken once both lanes are idle
// reset: voice playing, no fade, position zero; no clearing pass
// a result waiting in the output register does not block the next word; if
//   it is still not taken when the lanes finish, the lanes hold and item.ready
//   stays low
// ----------------------------------------------------------------------------
module voice_fade_gain_pan_mixer #(
    parameter int SAMPLE_BITS   = 16,
    parameter int BUS_BITS      = 24,
    parameter int RAMP_LEN_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    vfgp_in_if.sink                             item,
    vfgp_out_if.source                          result,
    input  logic                                cfg_write,
    input  logic [vfgp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [vfgp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    logic [vfgp_pkg::GAIN_BITS-1:0]       gain_reg;
    logic signed [vfgp_pkg::PAN_BITS-1:0] pan_reg;
    logic                                 mute_reg;
    logic                                 mono_reg;

    logic signed [vfgp_pkg::PAN_BITS-1:0] pan_clip;
    logic signed [vfgp_pkg::PAN_BITS-1:0] pan_left_diff;
    logic signed [vfgp_pkg::PAN_BITS-1:0] pan_right_sum;
    logic [vfgp_pkg::PF_BITS-1:0]         pf_left;
    logic [vfgp_pkg::PF_BITS-1:0]         pf_right;

    logic                                 accept;
    logic                                 frame_play;
    logic                                 fade_en;
    logic                                 use_voice;
    logic [RAMP_LEN_BITS-1:0]             num;
    logic [RAMP_LEN_BITS-1:0]             den;
    logic signed [SAMPLE_BITS-1:0]        sample_right_sel;
    vfgp_pkg::voice_stat_t                voice_stat;
    vfgp_pkg::lane_stat_t                 stat_left;
    vfgp_pkg::lane_stat_t                 stat_right;
    logic signed [BUS_BITS-1:0]           lane_left;
    logic signed [BUS_BITS-1:0]           lane_right;
    logic                                 ack;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= vfgp_pkg::GAIN_RESET;
            pan_reg  <= '0;
            mute_reg <= 1'b0;
            mono_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (vfgp_pkg::cfg_index_t'(cfg_index))
                vfgp_pkg::CFG_GAIN: gain_reg <= cfg_data[vfgp_pkg::GAIN_BITS-1:0];
                vfgp_pkg::CFG_PAN:  pan_reg  <= signed'(cfg_data[vfgp_pkg::PAN_BITS-1:0]);
                vfgp_pkg::CFG_MUTE: mute_reg <= cfg_data[0];
                vfgp_pkg::CFG_MONO: mono_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // clipped pan and per-channel pan factors
    always_comb
    begin
        if (pan_reg > vfgp_pkg::PAN_MAX)
        begin
            pan_clip = vfgp_pkg::PAN_MAX;
        end
        else if (pan_reg < vfgp_pkg::PAN_MIN)
        begin
            pan_clip = vfgp_pkg::PAN_MIN;
        end
        else
        begin
            pan_clip = pan_reg;
        end
    end

    assign pan_left_diff = vfgp_pkg::PAN_MAX - pan_clip;
    assign pan_right_sum = vfgp_pkg::PAN_MAX + pan_clip;
    assign pf_left  = (pan_clip > 0) ? pan_left_diff[vfgp_pkg::PF_BITS-1:0]
                                     : vfgp_pkg::PAN_UNITY;
    assign pf_right = (pan_clip < 0) ? pan_right_sum[vfgp_pkg::PF_BITS-1:0]
                                     : vfgp_pkg::PAN_UNITY;

    // word acceptance, one word in the lanes at a time
    assign item.ready = !stat_left.busy && !stat_right.busy;
    assign accept     = item.valid && item.ready;

    assign use_voice        = frame_play && !mute_reg && (gain_reg != '0);
    assign sample_right_sel = mono_reg ? item.sample_left : item.sample_right;

    vfgp_voice #(
        .RAMP_LEN_BITS (RAMP_LEN_BITS)
    ) u_voice (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .opcode      (item.opcode),
        .ramp_length (item.ramp_length),
        .frame_play  (frame_play),
        .fade_en     (fade_en),
        .num         (num),
        .den         (den),
        .stat        (voice_stat)
    );

    // left channel lane
    vfgp_lane #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .BUS_BITS      (BUS_BITS),
        .RAMP_LEN_BITS (RAMP_LEN_BITS)
    ) u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .fade_en    (fade_en),
        .use_voice  (use_voice),
        .sample     (item.sample_left),
        .bus        (item.bus_in_left),
        .num        (num),
        .den        (den),
        .gain       (gain_reg),
        .pan_factor (pf_left),
        .ack        (ack),
        .stat       (stat_left),
        .result     (lane_left)
    );

    // right channel lane
    vfgp_lane #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .BUS_BITS      (BUS_BITS),
        .RAMP_LEN_BITS (RAMP_LEN_BITS)
    ) u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .fade_en    (fade_en),
        .use_voice  (use_voice),
        .sample     (sample_right_sel),
        .bus        (item.bus_in_right),
        .num        (num),
        .den        (den),
        .gain       (gain_reg),
        .pan_factor (pf_right),
        .ack        (ack),
        .stat       (stat_right),
        .result     (lane_right)
    );

    vfgp_merge #(
        .BUS_BITS (BUS_BITS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .stat_left    (stat_left),
        .stat_right   (stat_right),
        .result_left  (lane_left),
        .result_right (lane_right),
        .voice        (voice_stat),
        .ack          (ack),
        .out          (result)
    );

endmodule

@@ hdl/vfgp_voice.sv @@
// ----------------------------------------------------------------------------
// vfgp_voice
// Voice play state, fade ramp counters and frame position.
// ----------------------------------------------------------------------------
module vfgp_voice #(
    parameter int RAMP_LEN_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [vfgp_pkg::OPCODE_BITS-1:0] opcode,
    input  logic [RAMP_LEN_BITS-1:0]         ramp_length,
    output logic                             frame_play,
    output logic                             fade_en,
    output logic [RAMP_LEN_BITS-1:0]         num,
    output logic [RAMP_LEN_BITS-1:0]         den,
    output vfgp_pkg::voice_stat_t            stat
);

    logic                          playing_reg, playing_next;
    vfgp_pkg::ramp_mode_t          ramp_mode_reg, ramp_mode_next;
    logic [RAMP_LEN_BITS-1:0]      ramp_count_reg, ramp_count_next;
    logic [RAMP_LEN_BITS-1:0]      ramp_total_reg, ramp_total_next;
    logic [vfgp_pkg::POS_BITS-1:0] frame_count_reg, frame_count_next;
    logic [RAMP_LEN_BITS-1:0]      count_inc;

    // fade factor of the current frame, from the state before it
    assign frame_play = (opcode == vfgp_pkg::OP_FRAME) && playing_reg;
    assign fade_en    = (ramp_mode_reg == vfgp_pkg::RAMP_IN) ||
                        (ramp_mode_reg == vfgp_pkg::RAMP_OUT);
    assign num        = (ramp_mode_reg == vfgp_pkg::RAMP_IN) ? ramp_count_reg
                                                             : ramp_total_reg - ramp_count_reg;
    assign den        = ramp_total_reg;
    assign count_inc  = ramp_count_reg + RAMP_LEN_BITS'(1);

    // next state per word
    always_comb
    begin
        playing_next     = playing_reg;
        ramp_mode_next   = ramp_mode_reg;
        ramp_count_next  = ramp_count_reg;
        ramp_total_next  = ramp_total_reg;
        frame_count_next = frame_count_reg;
        if (accept)
        begin
            unique case (vfgp_pkg::opcode_t'(opcode))
                vfgp_pkg::OP_FRAME:
                begin
                    if (playing_reg)
                    begin
                        frame_count_next = frame_count_reg + vfgp_pkg::POS_BITS'(1);
                        if (fade_en)
                        begin
                            ramp_count_next = count_inc;
                            // ramp done: the last frame still used its factor
                            if (count_inc >= ramp_total_reg)
                            begin
                                if (ramp_mode_reg == vfgp_pkg::RAMP_OUT)
                                begin
                                    playing_next = 1'b0;
                                end
                                ramp_mode_next  = vfgp_pkg::RAMP_NONE;
                                ramp_count_next = '0;
                            end
                        end
                    end
                end
                vfgp_pkg::OP_FADE_IN:
                begin
                    if ((ramp_length != '0) && !playing_reg)
                    begin
                        ramp_mode_next  = vfgp_pkg::RAMP_IN;
                        ramp_count_next = '0;
                        ramp_total_next = ramp_length;
                        playing_next    = 1'b1;
                    end
                end
                vfgp_pkg::OP_FADE_OUT:
                begin
                    if ((ramp_length != '0) && playing_reg)
                    begin
                        ramp_mode_next  = vfgp_pkg::RAMP_OUT;
                        ramp_count_next = '0;
                        ramp_total_next = ramp_length;
                    end
                end
                vfgp_pkg::OP_PLAY:
                begin
                    playing_next = 1'b1;
                end
                vfgp_pkg::OP_PAUSE:
                begin
                    playing_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // voice state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg     <= 1'b1;
            ramp_mode_reg   <= vfgp_pkg::RAMP_NONE;
            ramp_count_reg  <= '0;
            ramp_total_reg  <= '0;
            frame_count_reg <= '0;
        end
        else
        begin
            playing_reg     <= playing_next;
            ramp_mode_reg   <= ramp_mode_next;
            ramp_count_reg  <= ramp_count_next;
            ramp_total_reg  <= ramp_total_next;
            frame_count_reg <= frame_count_next;
        end
    end

    assign stat.playing     = playing_reg;
    assign stat.ramp_mode   = ramp_mode_reg;
    assign stat.frame_count = frame_count_reg;

    // a running ramp never reaches its total
    a_ramp_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ramp_mode_reg != vfgp_pkg::RAMP_NONE) |-> (ramp_count_reg < ramp_total_reg))
        else $error("ramp count reached total while fading");

endmodule

@@ hdl/vfgp_lane.sv @@
// ----------------------------------------------------------------------------
// vfgp_lane
// One channel of the voice: fade by bit-serial divide, gain and pan
// multiply, rounding and saturating add onto the bus value.
// ----------------------------------------------------------------------------
module vfgp_lane #(
    parameter int SAMPLE_BITS   = 16,
    parameter int BUS_BITS      = 24,
    parameter int RAMP_LEN_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               fade_en,
    input  logic                               use_voice,
    input  logic signed [SAMPLE_BITS-1:0]      sample,
    input  logic signed [BUS_BITS-1:0]         bus,
    input  logic [RAMP_LEN_BITS-1:0]           num,
    input  logic [RAMP_LEN_BITS-1:0]           den,
    input  logic [vfgp_pkg::GAIN_BITS-1:0]     gain,
    input  logic [vfgp_pkg::PF_BITS-1:0]       pan_factor,
    input  logic                               ack,
    output vfgp_pkg::lane_stat_t               stat,
    output logic signed [BUS_BITS-1:0]         result
);

    localparam int FW = SAMPLE_BITS + RAMP_LEN_BITS;
    localparam int MW = SAMPLE_BITS + vfgp_pkg::GP_BITS;
    localparam int SH = vfgp_pkg::PRODUCT_SHIFT - (BUS_BITS - SAMPLE_BITS);
    localparam int TW = (SH > 0) ? MW + 1 - SH : MW - SH;
    localparam int SW = ((TW > BUS_BITS) ? TW : BUS_BITS) + 2;
    localparam int CW = $clog2(SAMPLE_BITS);

    typedef enum logic [2:0] {
        L_IDLE,
        L_FADE,
        L_DIV,
        L_MULG,
        L_RND,
        L_SUM,
        L_HOLD
    } lane_state_t;

    lane_state_t                   state_reg, state_next;
    logic signed [BUS_BITS-1:0]    result_reg;
    logic                          neg_reg;
    logic                          fade_reg;
    logic                          use_reg;
    logic signed [BUS_BITS-1:0]    bus_reg;
    logic [SAMPLE_BITS-1:0]        mag_reg;
    logic [RAMP_LEN_BITS-1:0]      num_reg;
    logic [RAMP_LEN_BITS-1:0]      den_reg;
    logic [vfgp_pkg::GP_BITS-1:0]  gp_reg;
    logic [RAMP_LEN_BITS-1:0]      rem_reg;
    logic [SAMPLE_BITS-1:0]        q_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [MW-1:0]                 m_reg;
    logic [TW-1:0]                 t_reg;

    logic [SAMPLE_BITS-1:0]        sample_u;
    logic [SAMPLE_BITS-1:0]        mag_in;
    logic [FW-1:0]                 fprod;
    logic [RAMP_LEN_BITS:0]        rem2;
    logic [RAMP_LEN_BITS:0]        rem_sub;
    logic                          ge;
    logic [vfgp_pkg::GP_BITS-1:0]  gpm;
    logic [MW-1:0]                 mprod;
    logic [TW-1:0]                 t_comb;
    logic signed [SW-1:0]          bus_ext;
    logic signed [SW-1:0]          t_ext;
    logic signed [SW-1:0]          sum;
    logic                          fits;
    logic signed [BUS_BITS-1:0]    sat_val;
    logic signed [BUS_BITS-1:0]    res_next;

    // magnitude of the sample, the fade truncates toward zero
    assign sample_u = sample;
    assign mag_in   = sample[SAMPLE_BITS-1] ? (~sample_u + SAMPLE_BITS'(1)) : sample_u;

    // fade numerator product, top bits seed the divider remainder
    assign fprod = FW'(mag_reg) * FW'(num_reg);

    // one restoring divide step
    assign rem2    = {rem_reg, q_reg[SAMPLE_BITS-1]};
    assign ge      = rem2 >= {1'b0, den_reg};
    assign rem_sub = rem2 - {1'b0, den_reg};

    // gain times pan factor, then faded magnitude times that
    assign gpm   = vfgp_pkg::GP_BITS'(gain) * vfgp_pkg::GP_BITS'(pan_factor);
    assign mprod = MW'(q_reg) * MW'(gp_reg);

    // scale to bus width, rounding half away from zero on a right shift
    generate
        if (SH > 0)
        begin : g_round
            localparam logic [MW:0] HALF = (MW + 1)'(1) << (SH - 1);
            logic [MW:0] rsum;
            assign rsum   = {1'b0, m_reg} + HALF;
            assign t_comb = TW'(rsum >> SH);
        end
        else
        begin : g_widen
            assign t_comb = TW'(m_reg) << (-SH);
        end
    endgenerate

    // add or subtract the term, then saturate
    assign bus_ext  = SW'(bus_reg);
    assign t_ext    = use_reg ? signed'(SW'(t_reg)) : '0;
    assign sum      = neg_reg ? bus_ext - t_ext : bus_ext + t_ext;
    assign fits     = (&sum[SW-1:BUS_BITS-1]) || !(|sum[SW-1:BUS_BITS-1]);
    assign sat_val  = sum[SW-1] ? {1'b1, {(BUS_BITS-1){1'b0}}} : {1'b0, {(BUS_BITS-1){1'b1}}};
    assign res_next = fits ? sum[BUS_BITS-1:0] : sat_val;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE: if (start) state_next = L_FADE;
            L_FADE: state_next = fade_reg ? L_DIV : L_MULG;
            L_DIV:  if (cnt_reg == '0) state_next = L_MULG;
            L_MULG: state_next = L_RND;
            L_RND:  state_next = L_SUM;
            L_SUM:  state_next = L_HOLD;
            L_HOLD: if (ack) state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= L_IDLE;
            result_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == L_SUM)
            begin
                result_reg <= res_next;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    neg_reg  <= sample[SAMPLE_BITS-1];
                    mag_reg  <= mag_in;
                    bus_reg  <= bus;
                    fade_reg <= fade_en;
                    use_reg  <= use_voice;
                    num_reg  <= num;
                    den_reg  <= den;
                end
            end
            L_FADE:
            begin
                gp_reg <= gpm;
                if (fade_reg)
                begin
                    rem_reg <= fprod[FW-1:SAMPLE_BITS];
                    q_reg   <= fprod[SAMPLE_BITS-1:0];
                    cnt_reg <= CW'(SAMPLE_BITS - 1);
                end
                else
                begin
                    q_reg <= mag_reg;
                end
            end
            L_DIV:
            begin
                rem_reg <= ge ? rem_sub[RAMP_LEN_BITS-1:0] : rem2[RAMP_LEN_BITS-1:0];
                q_reg   <= {q_reg[SAMPLE_BITS-2:0], ge};
                cnt_reg <= cnt_reg - CW'(1);
            end
            L_MULG:
            begin
                m_reg <= mprod;
            end
            L_RND:
            begin
                t_reg <= t_comb;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.busy = (state_reg != L_IDLE);
    assign stat.rdy  = (state_reg == L_HOLD);
    assign result    = result_reg;

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == L_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    // a finished result waits untouched until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == L_HOLD) && !ack |=> (state_reg == L_HOLD) && $stable(result_reg))
        else $error("lane result lost before hand-over");

    // new words only reach an idle lane
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == L_IDLE))
        else $error("word started on a busy lane");

endmodule

@@ hdl/vfgp_merge.sv @@
// ----------------------------------------------------------------------------
// vfgp_merge
// Joins both lane results with the voice status into the output register.
// ----------------------------------------------------------------------------
module vfgp_merge #(
    parameter int BUS_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vfgp_pkg::lane_stat_t        stat_left,
    input  vfgp_pkg::lane_stat_t        stat_right,
    input  logic signed [BUS_BITS-1:0]  result_left,
    input  logic signed [BUS_BITS-1:0]  result_right,
    input  vfgp_pkg::voice_stat_t       voice,
    output logic                        ack,
    vfgp_out_if.source                  out
);

    logic                          valid_reg, valid_next;
    logic signed [BUS_BITS-1:0]    left_reg;
    logic signed [BUS_BITS-1:0]    right_reg;
    logic                          playing_reg;
    logic [1:0]                    ramp_reg;
    logic [vfgp_pkg::POS_BITS-1:0] pos_reg;
    logic                          load;

    // take both lanes once the output register is free or draining
    assign load       = stat_left.rdy && stat_right.rdy && (!valid_reg || out.ready);
    assign ack        = load;
    assign valid_next = load || (valid_reg && !out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg    <= result_left;
            right_reg   <= result_right;
            playing_reg <= voice.playing;
            ramp_reg    <= voice.ramp_mode;
            pos_reg     <= voice.frame_count;
        end
    end

    assign out.valid         = valid_reg;
    assign out.bus_out_left  = left_reg;
    assign out.bus_out_right = right_reg;
    assign out.is_playing    = playing_reg;
    assign out.ramp_state    = ramp_reg;
    assign out.position_now  = pos_reg;

    // both lanes run in lockstep
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (stat_left.rdy == stat_right.rdy) && (stat_left.busy == stat_right.busy))
        else $error("channel lanes out of step");

endmodule
